>>> src/rtc2epoch_pkg.sv
// shared types, constants and calendar tables for the rtc to epoch converter
package rtc2epoch_pkg;

  localparam logic [7:0]  BinaryBit   = 8'h04;
  localparam logic [7:0]  Hour24Bit   = 8'h02;
  localparam logic [7:0]  PmBit       = 8'h80;
  localparam logic [7:0]  HourMask    = 8'h7F;
  localparam logic [3:0]  NibbleMask  = 4'hF;
  localparam logic [14:0] EpochYear   = 15'd1970;
  localparam logic [14:0] LastYear    = 15'd2099;
  localparam logic [16:0] SecsPerDay  = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam int          Latency     = 4;

  typedef struct packed {
    logic [7:0]  sec;
    logic [7:0]  min;
    logic [7:0]  hr;
    logic [7:0]  day;
    logic [7:0]  mon;
    logic [14:0] year;
  } rtc_fields_t;

  function automatic logic [7:0] bcd_to_bin(input logic [7:0] v);
    logic [7:0] tens;
    logic [7:0] ones;
    tens = {4'd0, v[7:4] & NibbleMask};
    ones = {4'd0, v[3:0] & NibbleMask};
    return 8'((tens << 3) + (tens << 1) + ones);
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    unique case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [4:0] month_length(input logic [3:0] mon);
    logic [4:0] l;
    unique case (mon)
      4'd2:                      l = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
      default:                   l = 5'd31;
    endcase
    return l;
  endfunction

endpackage

>>> src/rtc_registers_to_epoch_seconds.sv
// rtc register snapshot to unix epoch seconds, four stage pipeline
// the start beat is registered through v1_r, v2_r, v3_r and v4_r to the out_valid strobe
// throughput: one beat per cycle; busy stays low, the pipeline never stalls
// stages: field decode, year multiply and range checks, day count, day-to-seconds multiply
// reset: synchronous active-low rst_n clears the stage valid bits only
module rtc_registers_to_epoch_seconds (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_seconds_raw,
  input  logic [7:0]  in_minutes_raw,
  input  logic [7:0]  in_hours_raw,
  input  logic [7:0]  in_day_raw,
  input  logic [7:0]  in_month_raw,
  input  logic [7:0]  in_year_raw,
  input  logic [7:0]  in_century_raw,
  input  logic [7:0]  in_status_b,
  output logic        out_valid,
  output logic [31:0] out_unix_seconds,
  output logic        out_date_valid,
  output logic [7:0]  out_seconds_out,
  output logic [7:0]  out_minutes_out,
  output logic [7:0]  out_hours_out,
  output logic [7:0]  out_day_out,
  output logic [7:0]  out_month_out,
  output logic [14:0] out_full_year
);
  import rtc2epoch_pkg::*;

  logic accept;

  // stage 1: decoded fields
  logic        v1_r;
  logic [7:0]  sec1_r, min1_r, hr1_r, day1_r, mon1_r, yr1_r, cen1_r;
  logic [7:0]  sec1_nxt, min1_nxt, hr1_nxt, day1_nxt, mon1_nxt, yr1_nxt, cen1_nxt;

  // stage 2: year, field checks, time of day
  logic        v2_r;
  rtc_fields_t f2_r, f2_nxt;
  logic        ok2_r, ok2_nxt;
  logic [16:0] tod2_r, tod2_nxt;
  logic [8:0]  dbm2_r, dbm2_nxt;
  logic [4:0]  mlen2_r, mlen2_nxt;

  // stage 3: day count and final validity
  logic        v3_r;
  rtc_fields_t f3_r;
  logic        ok3_r, ok3_nxt;
  logic [16:0] tod3_r;
  logic [15:0] days3_r, days3_nxt;

  // stage 4: output register
  logic        v4_r;
  rtc_fields_t f4_r;
  logic        ok4_r;
  logic [31:0] unix4_r, unix4_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_comb begin
    logic [7:0] hr_raw;
    logic       pm;
    logic       h24;
    logic       binary;
    binary = (in_status_b & BinaryBit) != 8'd0;
    h24    = (in_status_b & Hour24Bit) != 8'd0;
    pm     = !h24 && ((in_hours_raw & PmBit) != 8'd0);
    hr_raw = h24 ? in_hours_raw : (in_hours_raw & HourMask);
    if (binary) begin
      sec1_nxt = in_seconds_raw;
      min1_nxt = in_minutes_raw;
      hr1_nxt  = hr_raw;
      day1_nxt = in_day_raw;
      mon1_nxt = in_month_raw;
      yr1_nxt  = in_year_raw;
      cen1_nxt = in_century_raw;
    end else begin
      sec1_nxt = bcd_to_bin(in_seconds_raw);
      min1_nxt = bcd_to_bin(in_minutes_raw);
      hr1_nxt  = bcd_to_bin(hr_raw);
      day1_nxt = bcd_to_bin(in_day_raw);
      mon1_nxt = bcd_to_bin(in_month_raw);
      yr1_nxt  = bcd_to_bin(in_year_raw);
      cen1_nxt = bcd_to_bin(in_century_raw);
    end
    if (!h24) begin
      if (pm) begin
        if (hr1_nxt != 8'd12) begin
          hr1_nxt = hr1_nxt + 8'd12;
        end
      end else if (hr1_nxt == 8'd12) begin
        hr1_nxt = 8'd0;
      end
    end
  end

  always_comb begin
    f2_nxt.sec  = sec1_r;
    f2_nxt.min  = min1_r;
    f2_nxt.hr   = hr1_r;
    f2_nxt.day  = day1_r;
    f2_nxt.mon  = mon1_r;
    f2_nxt.year = 15'(cen1_r) * 15'd100 + {7'd0, yr1_r};
    ok2_nxt     = (sec1_r <= 8'd59) && (min1_r <= 8'd59) && (hr1_r <= 8'd23) &&
                  (mon1_r >= 8'd1) && (mon1_r <= 8'd12) && (day1_r >= 8'd1);
    tod2_nxt    = 17'(hr1_r[4:0]) * {5'd0, SecsPerHour} + 17'(min1_r[5:0]) * 17'd60
                + {11'd0, sec1_r[5:0]};
    dbm2_nxt    = days_before_month(mon1_r[3:0]);
    mlen2_nxt   = month_length(mon1_r[3:0]);
  end

  always_comb begin
    logic       leap;
    logic [4:0] mlen;
    logic [7:0] yoff;
    logic [8:0] yoff1;
    leap      = f2_r.year[1:0] == 2'd0;
    mlen      = (f2_r.mon == 8'd2 && leap) ? 5'd29 : mlen2_r;
    ok3_nxt   = ok2_r && (f2_r.year >= EpochYear) && (f2_r.year <= LastYear) &&
                (f2_r.day <= {3'd0, mlen});
    yoff      = 8'(f2_r.year - EpochYear);
    yoff1     = {1'b0, yoff} + 9'd1;
    days3_nxt = 16'(yoff) * 16'd365 + {9'd0, yoff1[8:2]} + {7'd0, dbm2_r}
              + {8'd0, f2_r.day - 8'd1}
              + {15'd0, leap && (f2_r.mon > 8'd2)};
  end

  always_comb begin
    unix4_nxt = ok3_r ? (32'(days3_r) * {15'd0, SecsPerDay} + {15'd0, tod3_r}) : 32'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    sec1_r  <= sec1_nxt;
    min1_r  <= min1_nxt;
    hr1_r   <= hr1_nxt;
    day1_r  <= day1_nxt;
    mon1_r  <= mon1_nxt;
    yr1_r   <= yr1_nxt;
    cen1_r  <= cen1_nxt;
    f2_r    <= f2_nxt;
    ok2_r   <= ok2_nxt;
    tod2_r  <= tod2_nxt;
    dbm2_r  <= dbm2_nxt;
    mlen2_r <= mlen2_nxt;
    f3_r    <= f2_r;
    ok3_r   <= ok3_nxt;
    tod3_r  <= tod2_r;
    days3_r <= days3_nxt;
    f4_r    <= f3_r;
    ok4_r   <= ok3_r;
    unix4_r <= unix4_nxt;
  end

  assign out_valid        = v4_r;
  assign out_unix_seconds = unix4_r;
  assign out_date_valid   = ok4_r;
  assign out_seconds_out  = f4_r.sec;
  assign out_minutes_out  = f4_r.min;
  assign out_hours_out    = f4_r.hr;
  assign out_day_out      = f4_r.day;
  assign out_month_out    = f4_r.mon;
  assign out_full_year    = f4_r.year;

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##4 out_valid)
    else $error("start beat did not reach the output after four cycles");

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_date_valid |-> out_unix_seconds == 32'd0)
    else $error("invalid date with nonzero epoch seconds");

  a_valid_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |->
      out_hours_out <= 8'd23 && out_month_out >= 8'd1 && out_month_out <= 8'd12 &&
      out_full_year >= EpochYear && out_full_year <= LastYear)
    else $error("date flagged valid with out of range fields");

  a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_date_valid |-> out_unix_seconds <= 32'd4102444799)
    else $error("epoch seconds beyond end of 2099");
`endif

endmodule
